@@ hw/rtl/pvca_pkg.sv @@
// pvca_pkg: shared types and constants for the priority voice channel allocator
// no dependencies; used by pvca_cmp and priority_voice_channel_allocator

package pvca_pkg;

    // request opcodes
    localparam logic [1:0] OP_PLAY     = 2'd0;
    localparam logic [1:0] OP_SET_PRIO = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHANNELS_IN_USE = 1'b0;
    localparam logic CFG_FLOOR_PRIORITY  = 1'b1;

    localparam int          ID_W        = 32;
    localparam int          CNT_W       = 28;
    localparam int          FRESH_SHIFT = 4;
    localparam logic [31:0] SLOT_MASK   = 32'h0000_000E;
    localparam logic [4:0]  CHANS_RESET = 5'd16;

    // result of the shared compare unit
    typedef struct packed {
        logic id_match;
        logic prio_le;
    } cmp_t;

endpackage

@@ hw/rtl/priority_voice_channel_allocator.sv @@
// priority_voice_channel_allocator: top level, sequencer around one compare unit
// depends on pvca_pkg, pvca_ram, pvca_cmp
//
// channel   | handshake         | payload
// ----------+-------------------+-------------------------------------------------
// request   | start, busy       | opcode, sound_id, sound_priority, channel
// result    | done (one cycle)  | accepted, chosen_channel, assigned_id, replaced_busy
// config    | cfg_we            | cfg_index, cfg_data
//
// a request is taken when start is high and busy is low; its result follows on done
// play: one table entry per cycle through the compare unit, over the active channels;
//   busy through S_SCAN and S_PLAY, done registered from S_PLAY
//   (an id match ends the scan early)
// set priority / clear: one read of the ram, busy through S_OP, done registered from S_OP
// ignored requests and plays with no active channel answer on the next cycle
// reset clears the table through per-channel valid bits, no clearing pass
// the receiver cannot stall; each result shows for exactly one cycle

module priority_voice_channel_allocator #(
    parameter int NUM_CHANNELS  = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // request
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [31:0]        sound_id,
    input  logic signed [15:0] sound_priority,
    input  logic [3:0]         channel,
    // result
    output logic               done,
    output logic               accepted,
    output logic [3:0]         chosen_channel,
    output logic [31:0]        assigned_id,
    output logic               replaced_busy,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);

    localparam int CW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNTW = $clog2(NUM_CHANNELS + 1);
    localparam int NW   = (CNTW > 5) ? CNTW : 5;
    localparam int AW4  = (CW > 4) ? CW : 4;
    localparam int EW   = pvca_pkg::ID_W + PRIORITY_BITS;

    // saturation limits for the stored priority
    localparam logic signed [32:0] PHI = (33'sd1 <<< (PRIORITY_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] PLO = -PHI - 33'sd1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PLAY = 2'd2;
    localparam logic [1:0] S_OP   = 2'd3;

    logic [1:0]                     state_reg,     state_next;
    logic [CW-1:0]                  cur_reg,       cur_next;
    logic [1:0]                     op_reg,        op_next;
    logic [3:0]                     chan_reg,      chan_next;
    logic [pvca_pkg::ID_W-1:0]      id_reg,        id_next;
    logic [PRIORITY_BITS-1:0]       prio_reg,      prio_next;
    logic [PRIORITY_BITS-1:0]       best_reg,      best_next;
    logic [CW-1:0]                  idx_reg,       idx_next;
    logic                           found_reg,     found_next;
    logic                           reject_reg,    reject_next;
    logic                           pick_busy_reg, pick_busy_next;
    logic [pvca_pkg::CNT_W-1:0]     counter_reg,   counter_next;
    logic [NUM_CHANNELS-1:0]        valid_reg,     valid_next;
    logic [4:0]                     chans_reg,     chans_next;
    logic                           floor_reg,     floor_next;
    logic                           done_reg,      done_next;
    logic                           acc_reg,       acc_next;
    logic [3:0]                     chosen_reg,    chosen_next;
    logic [pvca_pkg::ID_W-1:0]      outid_reg,     outid_next;
    logic                           rbusy_reg,     rbusy_next;

    // ram port
    logic                           ram_we;
    logic [CW-1:0]                  ram_waddr;
    logic [EW-1:0]                  ram_wdata;
    logic [CW-1:0]                  ram_raddr;
    logic [EW-1:0]                  ram_rdata;

    // helpers
    logic [NW-1:0]                  cfg_w;
    logic [NW-1:0]                  n_lim;
    logic [AW4-1:0]                 ch_in_w;
    logic [AW4-1:0]                 ch_reg_w;
    logic [AW4-1:0]                 idx_w;
    logic [CW-1:0]                  ch_in_addr;
    logic [CW-1:0]                  ch_reg_addr;
    logic signed [32:0]             p_raw;
    logic signed [32:0]             p_floor;
    logic signed [32:0]             p_sat;
    logic [PRIORITY_BITS-1:0]       prio_in;
    logic [pvca_pkg::CNT_W-1:0]     cnt_dec;
    logic                           need_fresh;
    logic [pvca_pkg::ID_W-1:0]      id_in;
    logic                           entry_valid;
    logic [pvca_pkg::ID_W-1:0]      entry_id;
    logic [PRIORITY_BITS-1:0]       entry_prio;
    logic                           last_entry;
    pvca_pkg::cmp_t                 cmp;

    // active channel count, capped at the table size
    assign cfg_w = NW'(chans_reg);
    assign n_lim = (cfg_w > NW'(NUM_CHANNELS)) ? NW'(NUM_CHANNELS) : cfg_w;

    assign ch_in_w     = AW4'(channel);
    assign ch_in_addr  = ch_in_w[CW-1:0];
    assign ch_reg_w    = AW4'(chan_reg);
    assign ch_reg_addr = ch_reg_w[CW-1:0];
    assign idx_w       = AW4'(idx_reg);

    // request priority: optional floor at zero, then saturate to the stored width
    assign p_raw   = 33'(sound_priority);
    assign p_floor = (floor_reg && (p_raw < 33'sd0)) ? 33'sd0 : p_raw;
    assign p_sat   = (p_floor > PHI) ? PHI : ((p_floor < PLO) ? PLO : p_floor);
    assign prio_in = p_sat[PRIORITY_BITS-1:0];

    // fresh id when the slot bits are all zero
    assign cnt_dec    = counter_reg - pvca_pkg::CNT_W'(1);
    assign need_fresh = ((sound_id & pvca_pkg::SLOT_MASK) == '0);
    assign id_in      = need_fresh ? {cnt_dec, {pvca_pkg::FRESH_SHIFT{1'b0}}} : sound_id;

    // entry read back from the ram; entries never written since reset read as zero
    assign entry_valid = (state_reg == S_OP) ? valid_reg[ch_reg_addr] : valid_reg[cur_reg];
    assign entry_id    = entry_valid ? ram_rdata[EW-1:PRIORITY_BITS] : '0;
    assign entry_prio  = entry_valid ? ram_rdata[PRIORITY_BITS-1:0] : '0;
    assign last_entry  = (NW'(cur_reg) == (n_lim - NW'(1)));

    pvca_cmp #(
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cmp (
        .entry_id   (entry_id),
        .entry_prio (entry_prio),
        .req_id     (id_reg),
        .best_prio  (best_reg),
        .result     (cmp)
    );

    pvca_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_CHANNELS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        op_next        = op_reg;
        chan_next      = chan_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        best_next      = best_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        reject_next    = reject_reg;
        pick_busy_next = pick_busy_reg;
        counter_next   = counter_reg;
        valid_next     = valid_reg;
        chans_next     = chans_reg;
        floor_next     = floor_reg;
        done_next      = 1'b0;
        acc_next       = acc_reg;
        chosen_next    = chosen_reg;
        outid_next     = outid_reg;
        rbusy_next     = rbusy_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = {id_reg, prio_reg};
        ram_raddr      = cur_reg + CW'(1);

        // configuration writes are to arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            if (cfg_index == pvca_pkg::CFG_CHANNELS_IN_USE)
            begin
                chans_next = cfg_data;
            end
            else
            begin
                floor_next = cfg_data[0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (opcode == pvca_pkg::OP_PLAY) ? '0 : ch_in_addr;
                if (start)
                begin
                    op_next   = opcode;
                    chan_next = channel;
                    prio_next = prio_in;
                    case (opcode)
                        pvca_pkg::OP_PLAY:
                        begin
                            if (need_fresh)
                            begin
                                counter_next = cnt_dec;
                            end
                            id_next        = id_in;
                            best_next      = prio_in;
                            cur_next       = '0;
                            found_next     = 1'b0;
                            reject_next    = 1'b0;
                            pick_busy_next = 1'b0;
                            if (n_lim == '0)
                            begin
                                // nothing to scan: reject at once
                                done_next   = 1'b1;
                                acc_next    = 1'b0;
                                chosen_next = '0;
                                outid_next  = id_in;
                                rbusy_next  = 1'b0;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        pvca_pkg::OP_SET_PRIO, pvca_pkg::OP_CLEAR:
                        begin
                            if (NW'(channel) < n_lim)
                            begin
                                state_next = S_OP;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                acc_next    = 1'b0;
                                chosen_next = '0;
                                outid_next  = '0;
                                rbusy_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            acc_next    = 1'b0;
                            chosen_next = '0;
                            outid_next  = '0;
                            rbusy_next  = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // next entry is already being read while this one is compared
                cur_next = cur_reg + CW'(1);
                if (cmp.id_match)
                begin
                    reject_next    = id_reg[0];
                    idx_next       = cur_reg;
                    found_next     = 1'b1;
                    pick_busy_next = (entry_id != '0);
                    state_next     = S_PLAY;
                end
                else
                begin
                    if (cmp.prio_le)
                    begin
                        idx_next       = cur_reg;
                        best_next      = entry_prio;
                        found_next     = 1'b1;
                        pick_busy_next = (entry_id != '0);
                    end
                    if (last_entry)
                    begin
                        state_next = S_PLAY;
                    end
                end
            end

            S_PLAY:
            begin
                done_next  = 1'b1;
                outid_next = id_reg;
                state_next = S_IDLE;
                if (found_reg && !reject_reg)
                begin
                    ram_we               = 1'b1;
                    valid_next[idx_reg]  = 1'b1;
                    acc_next             = 1'b1;
                    chosen_next          = idx_w[3:0];
                    rbusy_next           = pick_busy_reg;
                end
                else
                begin
                    acc_next    = 1'b0;
                    chosen_next = '0;
                    rbusy_next  = 1'b0;
                end
            end

            S_OP:
            begin
                done_next   = 1'b1;
                acc_next    = 1'b1;
                chosen_next = chan_reg;
                rbusy_next  = (entry_id != '0);
                ram_waddr   = ch_reg_addr;
                state_next  = S_IDLE;
                if (op_reg == pvca_pkg::OP_SET_PRIO)
                begin
                    ram_we                  = 1'b1;
                    ram_wdata               = {entry_id, prio_reg};
                    valid_next[ch_reg_addr] = 1'b1;
                    outid_next              = entry_id;
                end
                else
                begin
                    // invalid entry reads as empty with zero priority
                    valid_next[ch_reg_addr] = 1'b0;
                    outid_next              = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            op_reg        <= pvca_pkg::OP_PLAY;
            chan_reg      <= '0;
            id_reg        <= '0;
            prio_reg      <= '0;
            best_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            reject_reg    <= 1'b0;
            pick_busy_reg <= 1'b0;
            counter_reg   <= '0;
            valid_reg     <= '0;
            chans_reg     <= pvca_pkg::CHANS_RESET;
            floor_reg     <= 1'b1;
            done_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            chosen_reg    <= '0;
            outid_reg     <= '0;
            rbusy_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            op_reg        <= op_next;
            chan_reg      <= chan_next;
            id_reg        <= id_next;
            prio_reg      <= prio_next;
            best_reg      <= best_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            reject_reg    <= reject_next;
            pick_busy_reg <= pick_busy_next;
            counter_reg   <= counter_next;
            valid_reg     <= valid_next;
            chans_reg     <= chans_next;
            floor_reg     <= floor_next;
            done_reg      <= done_next;
            acc_reg       <= acc_next;
            chosen_reg    <= chosen_next;
            outid_reg     <= outid_next;
            rbusy_reg     <= rbusy_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign accepted       = acc_reg;
    assign chosen_channel = chosen_reg;
    assign assigned_id    = outid_reg;
    assign replaced_busy  = rbusy_reg;

endmodule

@@ hw/rtl/pvca_ram.sv @@
// pvca_ram: generic single write port, single read port ram with registered read
// no dependencies

module pvca_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/pvca_cmp.sv @@
// pvca_cmp: shared compare unit, one table entry against the request per cycle
// depends on pvca_pkg

module pvca_cmp #(
    parameter int PRIORITY_BITS = 16
) (
    input  logic [pvca_pkg::ID_W-1:0]  entry_id,
    input  logic [PRIORITY_BITS-1:0]   entry_prio,
    input  logic [pvca_pkg::ID_W-1:0]  req_id,
    input  logic [PRIORITY_BITS-1:0]   best_prio,
    output pvca_pkg::cmp_t             result
);

    // ids compare without the protect bit
    assign result.id_match = (entry_id[pvca_pkg::ID_W-1:1] == req_id[pvca_pkg::ID_W-1:1]);
    assign result.prio_le  = ($signed(entry_prio) <= $signed(best_prio));

endmodule
